// File: design/lesm_pkg.sv
// Shared types and constants for the log entry signature matcher.
// Holds the signature list, field and reason codes. No dependencies.
package lesm_pkg;

   localparam int WIN_DEPTH = 11;
   localparam int VIEW_LEN = WIN_DEPTH + 1;
   localparam int VIEW_BITS = 8 * VIEW_LEN;
   localparam int URL_LEN_BITS = 16;
   localparam int CSR_ADDR_BITS = 3;

   typedef logic [VIEW_BITS-1:0] view_type;

   // Field tags of the request stream
   localparam logic [1:0] FIELD_URL = 2'd0;
   localparam logic [1:0] FIELD_AGENT = 2'd1;
   localparam logic [1:0] FIELD_METHOD = 2'd2;
   localparam logic [1:0] FIELD_NONE = 2'd3;

   // Hit flag bit positions
   localparam int HIT_SQL = 0;
   localparam int HIT_TRAVERSAL = 1;
   localparam int HIT_AGENT = 2;
   localparam int HIT_METHOD = 3;
   localparam int HIT_COUNT = 4;

   typedef logic [HIT_COUNT-1:0] hit_type;

   typedef enum logic [2:0] {
      REASON_NONE = 3'd0,
      REASON_SQL = 3'd1,
      REASON_TRAVERSAL = 3'd2,
      REASON_AGENT = 3'd3,
      REASON_METHOD = 3'd4,
      REASON_LONG_URL = 3'd5
   } reason_type;

   // Register word index
   localparam logic CSR_MAX_URL_LENGTH = 1'b0;
   localparam logic [15:0] MAX_URL_LENGTH_RESET = 16'd512;

   // Text is right aligned: last character in the low byte, matching the view
   typedef struct packed {
      logic [VIEW_BITS-1:0] text;
      logic [3:0] len;
      logic [1:0] flag;
      logic [1:0] field;
   } sig_type;

   localparam int SIG_COUNT = 27;

   localparam sig_type SIG_TABLE [SIG_COUNT] = '{
      '{"' OR ", 4'd5, 2'd0, FIELD_URL},
      '{"' or ", 4'd5, 2'd0, FIELD_URL},
      '{"1=1", 4'd3, 2'd0, FIELD_URL},
      '{"OR 1=1", 4'd6, 2'd0, FIELD_URL},
      '{"UNION SELECT", 4'd12, 2'd0, FIELD_URL},
      '{"union select", 4'd12, 2'd0, FIELD_URL},
      '{"DROP TABLE", 4'd10, 2'd0, FIELD_URL},
      '{"drop table", 4'd10, 2'd0, FIELD_URL},
      '{"--", 4'd2, 2'd0, FIELD_URL},
      '{";--", 4'd3, 2'd0, FIELD_URL},
      '{"xp_", 4'd3, 2'd0, FIELD_URL},
      '{"../", 4'd3, 2'd1, FIELD_URL},
      '{"..\\", 4'd3, 2'd1, FIELD_URL},
      '{"%2e%2e%2f", 4'd9, 2'd1, FIELD_URL},
      '{"%252e%252e", 4'd10, 2'd1, FIELD_URL},
      '{"sqlmap", 4'd6, 2'd2, FIELD_AGENT},
      '{"nikto", 4'd5, 2'd2, FIELD_AGENT},
      '{"nmap", 4'd4, 2'd2, FIELD_AGENT},
      '{"masscan", 4'd7, 2'd2, FIELD_AGENT},
      '{"zgrab", 4'd5, 2'd2, FIELD_AGENT},
      '{"dirbuster", 4'd9, 2'd2, FIELD_AGENT},
      '{"nuclei", 4'd6, 2'd2, FIELD_AGENT},
      '{"acunetix", 4'd8, 2'd2, FIELD_AGENT},
      '{"burpsuite", 4'd9, 2'd2, FIELD_AGENT},
      '{"TRACE", 4'd5, 2'd3, FIELD_METHOD},
      '{"TRACK", 4'd5, 2'd3, FIELD_METHOD},
      '{"DEBUG", 4'd5, 2'd3, FIELD_METHOD}
   };

endpackage

// File: design/lesm_matcher.sv
// Parallel suffix compare of the byte view against every signature.
// Depends on lesm_pkg for the signature list and field codes.
module lesm_matcher
   import lesm_pkg::*;
(
   input  view_type   view,
   input  logic [1:0] mode,
   output hit_type    hits
);

   logic [SIG_COUNT-1:0] sig_hit;

   for (genvar i = 0; i < SIG_COUNT; i++) begin : g_sig
      localparam int LEN = int'(SIG_TABLE[i].len);
      localparam view_type MASK = {VIEW_BITS{1'b1}} >> (VIEW_BITS - 8 * LEN);
      assign sig_hit[i] = (mode == SIG_TABLE[i].field)
                          && (((view ^ SIG_TABLE[i].text) & MASK) == '0);
   end

   always_comb begin
      hits = '0;
      for (int i = 0; i < SIG_COUNT; i++) begin
         if (sig_hit[i]) begin
            hits[SIG_TABLE[i].flag] = 1'b1;
         end
      end
   end

endmodule

// File: design/log_entry_signature_matcher_top.sv
// Top level of the log entry signature matcher: entry state, reason logic,
// output buffer and register port. Depends on lesm_pkg and lesm_matcher.
//
// One request is taken per clock cycle while req_stall is low. Each byte is
// compared in the same cycle against all signatures of its field over the last
// eleven bytes of that field plus itself, and the entry state (window, field,
// hit flags, URL count) updates at the accepting edge. A request with
// end_of_entry set yields one response through a result register backed by a
// one-entry skid stage, so requests keep flowing while a response waits;
// req_stall rises only when both are full.
module log_entry_signature_matcher_top
   import lesm_pkg::*;
#(
   parameter int LENGTH_COUNTER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [7:0]               req_byte_value,
   input  logic                     req_has_byte,
   input  logic                     req_end_of_entry,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_reason,
   output logic [URL_LEN_BITS-1:0]  rsp_url_length,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int CMP_BITS = (LENGTH_COUNTER_BITS > URL_LEN_BITS) ?
                             LENGTH_COUNTER_BITS : URL_LEN_BITS;
   localparam logic [LENGTH_COUNTER_BITS-1:0] COUNT_MAX = '1;

   logic [7:0]                     byte_window_ff [WIN_DEPTH];
   logic [7:0]                     byte_window_in [WIN_DEPTH];
   logic [1:0]                     current_field_ff, current_field_in;
   hit_type                        hit_flags_ff, hit_flags_in;
   logic [LENGTH_COUNTER_BITS-1:0] url_count_ff, url_count_in;
   logic [15:0]                    max_url_length_ff;

   logic                           out_valid_ff, skid_valid_ff;
   reason_type                     out_reason_ff, skid_reason_ff;
   logic [URL_LEN_BITS-1:0]        out_length_ff, skid_length_ff;

   logic                           req_accept, take_byte, field_change, out_free;
   logic                           new_result;
   view_type                       view;
   hit_type                        hits, flags_after;
   logic [LENGTH_COUNTER_BITS-1:0] count_after;
   logic [CMP_BITS-1:0]            count_wide;
   reason_type                     new_reason;
   logic [URL_LEN_BITS-1:0]        new_length;

   assign req_stall = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign take_byte = req_accept && req_has_byte && (req_mode != FIELD_NONE);
   assign field_change = req_mode != current_field_ff;

   // Newest byte in the low byte of the view
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         view[8*(VIEW_LEN-1-i) +: 8] = field_change ? 8'h00 : byte_window_ff[i];
      end
      view[7:0] = req_byte_value;
   end

   lesm_matcher u_matcher (
      .view (view),
      .mode (req_mode),
      .hits (hits)
   );

   always_comb begin
      flags_after = hit_flags_ff;
      count_after = url_count_ff;
      if (take_byte) begin
         flags_after = hit_flags_ff | hits;
         if (req_mode == FIELD_URL && url_count_ff != COUNT_MAX) begin
            count_after = url_count_ff + 1'b1;
         end
      end
   end

   assign count_wide = CMP_BITS'(count_after);
   assign new_length = (count_wide > CMP_BITS'(16'hFFFF)) ? 16'hFFFF :
                       count_wide[URL_LEN_BITS-1:0];

   always_comb begin
      if (flags_after[HIT_SQL]) begin
         new_reason = REASON_SQL;
      end else if (flags_after[HIT_TRAVERSAL]) begin
         new_reason = REASON_TRAVERSAL;
      end else if (flags_after[HIT_AGENT]) begin
         new_reason = REASON_AGENT;
      end else if (flags_after[HIT_METHOD]) begin
         new_reason = REASON_METHOD;
      end else if (count_wide > CMP_BITS'(max_url_length_ff)) begin
         new_reason = REASON_LONG_URL;
      end else begin
         new_reason = REASON_NONE;
      end
   end

   // Entry state next values; end of entry returns everything to reset
   always_comb begin
      byte_window_in = byte_window_ff;
      current_field_in = current_field_ff;
      if (take_byte) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            byte_window_in[i] = view[8*(VIEW_LEN-2-i) +: 8];
         end
         current_field_in = req_mode;
      end
      hit_flags_in = flags_after;
      url_count_in = count_after;
      if (req_accept && req_end_of_entry) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            byte_window_in[i] = 8'h00;
         end
         current_field_in = FIELD_URL;
         hit_flags_in = '0;
         url_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            byte_window_ff[i] <= 8'h00;
         end
         current_field_ff <= FIELD_URL;
         hit_flags_ff <= '0;
         url_count_ff <= '0;
      end else if (req_accept) begin
         byte_window_ff <= byte_window_in;
         current_field_ff <= current_field_in;
         hit_flags_ff <= hit_flags_in;
         url_count_ff <= url_count_in;
      end
   end

   // Result register with skid stage
   assign new_result = req_accept && req_end_of_entry;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= skid_valid_ff || new_result;
         skid_valid_ff <= 1'b0;
      end else if (new_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_reason_ff <= skid_reason_ff;
            out_length_ff <= skid_length_ff;
         end else begin
            out_reason_ff <= new_reason;
            out_length_ff <= new_length;
         end
      end else if (new_result) begin
         skid_reason_ff <= new_reason;
         skid_length_ff <= new_length;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_reason = out_reason_ff;
   assign rsp_url_length = out_length_ff;

   // Register port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_url_length_ff <= MAX_URL_LENGTH_RESET;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == CSR_MAX_URL_LENGTH) begin
         max_url_length_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr[2] == CSR_MAX_URL_LENGTH) ? {16'h0000, max_url_length_ff} : 32'h0;

endmodule
